FILE: rtl/seed_hit_confidence_controller_defines.svh
// assertion macros for the seed hit confidence controller
`ifndef SEED_HIT_CONFIDENCE_CONTROLLER_DEFINES_SVH
`define SEED_HIT_CONFIDENCE_CONTROLLER_DEFINES_SVH

// same-cycle implication, off during reset
`define SHCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shcc assertion failed");

// next-cycle implication, off during reset
`define SHCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shcc assertion failed");

`endif

FILE: rtl/shcc_pkg.sv
// shared types and constants for the seed hit confidence controller
`default_nettype none

package shcc_pkg;

  localparam int DIST_WIDTH_DEF = 16;
  localparam int POS_WIDTH_DEF  = 32;

  localparam int ED_MAX_WIDTH    = 10;
  localparam int CONF_WIDTH      = 8;
  localparam int SEED_CNT_WIDTH  = 10;
  localparam int CFG_IDX_WIDTH   = 2;
  localparam int CFG_DATA_WIDTH  = 10;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ED_MAX     = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CONFIDENCE = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SEED_TOTAL = 2'd2;

  localparam logic [ED_MAX_WIDTH-1:0]   ED_MAX_RST     = 10'd8;
  localparam logic [CONF_WIDTH-1:0]     CONFIDENCE_RST = 8'd2;
  localparam logic [SEED_CNT_WIDTH-1:0] SEED_TOTAL_RST = 10'd4;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_SINGLE   = 2'd1,
    VERDICT_MULTI    = 2'd2,
    VERDICT_NONE     = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [ED_MAX_WIDTH-1:0]   ed_max;
    logic [CONF_WIDTH-1:0]     confidence;
    logic [SEED_CNT_WIDTH-1:0] seed_total;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/shcc_limit.sv
// distance limit for the next seed, from the tracked best and second best
`default_nettype none

module shcc_limit #(
  parameter int DIST_WIDTH = shcc_pkg::DIST_WIDTH_DEF
) (
  input  logic [DIST_WIDTH-1:0] best_dist,
  input  logic [DIST_WIDTH-1:0] second_dist,
  input  shcc_pkg::cfg_t        cfg,
  output logic [DIST_WIDTH-1:0] limit
);

  localparam int SUM_WIDTH =
    ((DIST_WIDTH > shcc_pkg::SEED_CNT_WIDTH) ? DIST_WIDTH : shcc_pkg::SEED_CNT_WIDTH) + 1;

  logic [SUM_WIDTH-1:0] best_ext;
  logic [SUM_WIDTH-1:0] second_ext;
  logic [SUM_WIDTH-1:0] ed_max_ext;
  logic [SUM_WIDTH-1:0] conf_ext;
  logic [SUM_WIDTH-1:0] best_conf;
  logic [SUM_WIDTH-1:0] base;
  logic [SUM_WIDTH-1:0] base_dec;

  always_comb begin
    best_ext   = SUM_WIDTH'(best_dist);
    second_ext = SUM_WIDTH'(second_dist);
    ed_max_ext = SUM_WIDTH'(cfg.ed_max);
    conf_ext   = SUM_WIDTH'(cfg.confidence);
    best_conf  = best_ext + conf_ext;

    if (best_ext > ed_max_ext) begin
      base = ed_max_ext + conf_ext;
    end else if (second_ext >= best_conf) begin
      base = best_conf;
    end else begin
      base = best_ext;
    end

    base_dec = base - SUM_WIDTH'(1);

    // floor at zero, ceiling at all ones
    if (base == '0) begin
      limit = '0;
    end else if (base_dec[SUM_WIDTH-1:DIST_WIDTH] != '0) begin
      limit = '1;
    end else begin
      limit = base_dec[DIST_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/shcc_track.sv
// best / second-best tracking state, seed count and verdict logic
`default_nettype none
`include "seed_hit_confidence_controller_defines.svh"

module shcc_track #(
  parameter int DIST_WIDTH = shcc_pkg::DIST_WIDTH_DEF,
  parameter int POS_WIDTH  = shcc_pkg::POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [DIST_WIDTH-1:0] new_distance,
  input  logic [POS_WIDTH-1:0]  new_position,
  input  logic                  last_seed,
  input  shcc_pkg::cfg_t        cfg,
  output shcc_pkg::verdict_t    verdict,
  output logic [DIST_WIDTH-1:0] best_distance,
  output logic [POS_WIDTH-1:0]  best_position,
  output logic [DIST_WIDTH-1:0] lim_best,
  output logic [DIST_WIDTH-1:0] lim_second
);

  localparam int SUM_WIDTH =
    ((DIST_WIDTH > shcc_pkg::SEED_CNT_WIDTH) ? DIST_WIDTH : shcc_pkg::SEED_CNT_WIDTH) + 1;

  logic [DIST_WIDTH-1:0]               best_dist;
  logic [POS_WIDTH-1:0]                best_pos;
  logic [DIST_WIDTH-1:0]               second_dist;
  logic [POS_WIDTH-1:0]                second_pos;
  logic [shcc_pkg::SEED_CNT_WIDTH-1:0] seed_count;

  logic [DIST_WIDTH-1:0]               best_dist_upd;
  logic [POS_WIDTH-1:0]                best_pos_upd;
  logic [DIST_WIDTH-1:0]               second_dist_upd;
  logic [POS_WIDTH-1:0]                second_pos_upd;
  logic [shcc_pkg::SEED_CNT_WIDTH-1:0] seed_count_upd;

  logic [DIST_WIDTH-1:0]               best_dist_next;
  logic [POS_WIDTH-1:0]                best_pos_next;
  logic [DIST_WIDTH-1:0]               second_dist_next;
  logic [POS_WIDTH-1:0]                second_pos_next;
  logic [shcc_pkg::SEED_CNT_WIDTH-1:0] seed_count_next;

  logic [SUM_WIDTH-1:0] best_ext;
  logic [SUM_WIDTH-1:0] second_ext;
  logic [SUM_WIDTH-1:0] conf_ext;
  logic [SUM_WIDTH-1:0] best_conf;
  logic [SUM_WIDTH-1:0] count_ext;
  logic [SUM_WIDTH-1:0] total_ext;
  logic                 early_multi;
  logic                 ended;
  logic                 within_max;

  always_comb begin
    best_dist_upd   = best_dist;
    best_pos_upd    = best_pos;
    second_dist_upd = second_dist;
    second_pos_upd  = second_pos;

    if (new_distance < best_dist) begin
      second_dist_upd = best_dist;
      second_pos_upd  = best_pos;
      best_dist_upd   = new_distance;
      best_pos_upd    = new_position;
    end else if (new_distance > best_dist && new_distance < second_dist) begin
      second_dist_upd = new_distance;
      second_pos_upd  = new_position;
    end

    if (seed_count < cfg.seed_total) begin
      seed_count_upd = seed_count + shcc_pkg::SEED_CNT_WIDTH'(1);
    end else begin
      seed_count_upd = seed_count;
    end

    best_ext   = SUM_WIDTH'(best_dist_upd);
    second_ext = SUM_WIDTH'(second_dist_upd);
    conf_ext   = SUM_WIDTH'(cfg.confidence);
    best_conf  = best_ext + conf_ext;
    count_ext  = SUM_WIDTH'(seed_count_upd);
    total_ext  = SUM_WIDTH'(cfg.seed_total);
    within_max = best_ext <= SUM_WIDTH'(cfg.ed_max);

    // two near-equal hits already below the margin
    early_multi = (best_ext < conf_ext) && (second_ext < best_conf);
    ended = !early_multi &&
            ((count_ext >= best_conf) ||
             ((seed_count_upd == cfg.seed_total) && (best_ext > total_ext)) ||
             last_seed);

    if (early_multi) begin
      verdict = shcc_pkg::VERDICT_MULTI;
    end else if (ended) begin
      if (within_max && second_ext >= best_conf) begin
        verdict = shcc_pkg::VERDICT_SINGLE;
      end else if (within_max) begin
        verdict = shcc_pkg::VERDICT_MULTI;
      end else begin
        verdict = shcc_pkg::VERDICT_NONE;
      end
    end else begin
      verdict = shcc_pkg::VERDICT_CONTINUE;
    end

    // a verdict closes the read
    if (verdict != shcc_pkg::VERDICT_CONTINUE) begin
      best_dist_next   = '1;
      best_pos_next    = '0;
      second_dist_next = '1;
      second_pos_next  = '0;
      seed_count_next  = '0;
    end else begin
      best_dist_next   = best_dist_upd;
      best_pos_next    = best_pos_upd;
      second_dist_next = second_dist_upd;
      second_pos_next  = second_pos_upd;
      seed_count_next  = seed_count_upd;
    end
  end

  assign best_distance = best_dist_upd;
  assign best_position = best_pos_upd;
  assign lim_best      = best_dist_next;
  assign lim_second    = second_dist_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist   <= '1;
      best_pos    <= '0;
      second_dist <= '1;
      second_pos  <= '0;
      seed_count  <= '0;
    end else if (step) begin
      best_dist   <= best_dist_next;
      best_pos    <= best_pos_next;
      second_dist <= second_dist_next;
      second_pos  <= second_pos_next;
      seed_count  <= seed_count_next;
    end
  end

  `SHCC_ASSERT_NOW(a_best_not_above_second, clk, rst, 1'b1, best_dist <= second_dist)
  `SHCC_ASSERT_NEXT(a_clear_after_verdict, clk, rst, step && verdict != shcc_pkg::VERDICT_CONTINUE, best_dist == '1 && second_dist == '1 && seed_count == '0)
  `SHCC_ASSERT_NEXT(a_count_steps_by_one, clk, rst, step, seed_count == '0 || seed_count == $past(seed_count) || seed_count == $past(seed_count) + shcc_pkg::SEED_CNT_WIDTH'(1))

endmodule

`default_nettype wire

FILE: rtl/seed_hit_confidence_controller.sv
// throughput: one item per cycle while not stalled by out_ready, set by the single pass from
// input register to result register; the tracking state is updated in the same pass, so
// back-to-back seeds see it at once
// reset: synchronous, clears both pipeline stages and the tracking state,
// and loads the registers with ed_max 8, confidence 2, seed total 4
`default_nettype none
`include "seed_hit_confidence_controller_defines.svh"

module seed_hit_confidence_controller #(
  parameter int DIST_WIDTH = shcc_pkg::DIST_WIDTH_DEF,
  parameter int POS_WIDTH  = shcc_pkg::POS_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [DIST_WIDTH-1:0]                new_distance,
  input  logic [POS_WIDTH-1:0]                 new_position,
  input  logic                                 last_seed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [DIST_WIDTH-1:0]                next_limit,
  output logic [1:0]                           verdict,
  output logic [POS_WIDTH-1:0]                 best_position,
  output logic [DIST_WIDTH-1:0]                best_distance,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [shcc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [shcc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  shcc_pkg::cfg_t cfg;

  logic                  in_q_valid;
  logic [DIST_WIDTH-1:0] in_q_dist;
  logic [POS_WIDTH-1:0]  in_q_pos;
  logic                  in_q_last;
  logic                  advance;

  shcc_pkg::verdict_t    step_verdict;
  logic [DIST_WIDTH-1:0] step_best_dist;
  logic [POS_WIDTH-1:0]  step_best_pos;
  logic [DIST_WIDTH-1:0] lim_best;
  logic [DIST_WIDTH-1:0] lim_second;
  logic [DIST_WIDTH-1:0] step_limit;

  shcc_pkg::verdict_t    res_verdict;
  logic [DIST_WIDTH-1:0] res_limit;
  logic [POS_WIDTH-1:0]  res_pos;
  logic [DIST_WIDTH-1:0] res_dist;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ed_max     <= shcc_pkg::ED_MAX_RST;
      cfg.confidence <= shcc_pkg::CONFIDENCE_RST;
      cfg.seed_total <= shcc_pkg::SEED_TOTAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        shcc_pkg::CFG_ED_MAX: begin
          cfg.ed_max <= cfg_data[shcc_pkg::ED_MAX_WIDTH-1:0];
        end
        shcc_pkg::CFG_CONFIDENCE: begin
          cfg.confidence <= cfg_data[shcc_pkg::CONF_WIDTH-1:0];
        end
        shcc_pkg::CFG_SEED_TOTAL: begin
          cfg.seed_total <= cfg_data[shcc_pkg::SEED_CNT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // input stage moves on whenever the result register is free or being drained
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_dist <= new_distance;
      in_q_pos  <= new_position;
      in_q_last <= last_seed;
    end
  end

  shcc_track #(
    .DIST_WIDTH (DIST_WIDTH),
    .POS_WIDTH  (POS_WIDTH)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .new_distance  (in_q_dist),
    .new_position  (in_q_pos),
    .last_seed     (in_q_last),
    .cfg           (cfg),
    .verdict       (step_verdict),
    .best_distance (step_best_dist),
    .best_position (step_best_pos),
    .lim_best      (lim_best),
    .lim_second    (lim_second)
  );

  shcc_limit #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_limit (
    .best_dist   (lim_best),
    .second_dist (lim_second),
    .cfg         (cfg),
    .limit       (step_limit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_verdict <= step_verdict;
      res_limit   <= step_limit;
      res_pos     <= step_best_pos;
      res_dist    <= step_best_dist;
    end
  end

  assign next_limit    = res_limit;
  assign verdict       = res_verdict;
  assign best_position = res_pos;
  assign best_distance = res_dist;

  `SHCC_ASSERT_NEXT(a_input_stage_holds, clk, rst, in_q_valid && !advance, in_q_valid)
  `SHCC_ASSERT_NEXT(a_result_loads, clk, rst, advance, out_valid)
  `SHCC_ASSERT_NOW(a_no_advance_when_blocked, clk, rst, out_valid && !out_ready, !advance && (in_ready == !in_q_valid))

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the seed hit confidence controller
module tb_top;

  localparam int DW = shcc_pkg::DIST_WIDTH_DEF;
  localparam int PW = shcc_pkg::POS_WIDTH_DEF;
  // index 3 has no register behind it, writes there must be dropped
  localparam logic [shcc_pkg::CFG_IDX_WIDTH-1:0] CFG_SPARE = 2'd3;
  localparam logic [DW-1:0] DIST_NONE = '1;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 8;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [DW-1:0]      next_limit;
    shcc_pkg::verdict_t verdict;
    logic [PW-1:0]      position;
    logic [DW-1:0]      distance;
  } hit_t;

  typedef struct packed {
    logic [DW-1:0] distance;
    logic [PW-1:0] position;
    logic          last;
    logic          typed;
    hit_t          want;
  } seed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DW-1:0] new_distance = '0;
  logic [PW-1:0] new_position = '0;
  logic last_seed = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DW-1:0] next_limit;
  logic [1:0] verdict;
  logic [PW-1:0] best_position;
  logic [DW-1:0] best_distance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [shcc_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [shcc_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;

  // register copies and tracking state of the predictor
  logic [shcc_pkg::ED_MAX_WIDTH-1:0] ed_max_reg = shcc_pkg::ED_MAX_RST;
  logic [shcc_pkg::CONF_WIDTH-1:0] conf_reg = shcc_pkg::CONFIDENCE_RST;
  logic [shcc_pkg::SEED_CNT_WIDTH-1:0] seed_total_reg = shcc_pkg::SEED_TOTAL_RST;
  logic [DW-1:0] best_dist, second_dist;
  logic [PW-1:0] best_pos, second_pos;
  logic [shcc_pkg::SEED_CNT_WIDTH-1:0] seeds_seen;

  hit_t hits_due[$];
  seed_row_t directed_rows[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  seed_hit_confidence_controller DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .new_distance(new_distance),
    .new_position(new_position),
    .last_seed(last_seed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_limit(next_limit),
    .verdict(verdict),
    .best_position(best_position),
    .best_distance(best_distance),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_read_state();
    best_dist = DIST_NONE;
    best_pos = '0;
    second_dist = DIST_NONE;
    second_pos = '0;
    seeds_seen = '0;
  endfunction

  // updates best / second best for one seed and returns the result it causes
  function automatic hit_t track_seed(logic [DW-1:0] nd, logic [PW-1:0] np, logic last);
    int unsigned best, second, margin, lim;
    logic ended;
    hit_t h;
    ended = 1'b0;
    h.verdict = shcc_pkg::VERDICT_CONTINUE;
    if (nd < best_dist) begin
      second_dist = best_dist;
      second_pos = best_pos;
      best_dist = nd;
      best_pos = np;
    end else if (nd > best_dist && nd < second_dist) begin
      second_dist = nd;
      second_pos = np;
    end
    if (seeds_seen < seed_total_reg) seeds_seen = seeds_seen + 1'b1;
    best = best_dist;
    second = second_dist;
    margin = conf_reg;
    if (best < margin && second < best + margin) h.verdict = shcc_pkg::VERDICT_MULTI;
    else if (seeds_seen >= best + margin) ended = 1'b1;
    else if (seeds_seen == seed_total_reg && best > seed_total_reg) ended = 1'b1;
    else if (last) ended = 1'b1;
    if (ended) begin
      if (best <= ed_max_reg && second >= best + margin) h.verdict = shcc_pkg::VERDICT_SINGLE;
      else if (best <= ed_max_reg) h.verdict = shcc_pkg::VERDICT_MULTI;
      else h.verdict = shcc_pkg::VERDICT_NONE;
    end
    h.position = best_pos;
    h.distance = best_dist;
    if (h.verdict != shcc_pkg::VERDICT_CONTINUE) clear_read_state();
    // limit comes from the state left behind, after clearing
    best = best_dist;
    second = second_dist;
    if (best > ed_max_reg) lim = ed_max_reg + margin;
    else if (second >= best + margin) lim = best + margin;
    else lim = best;
    lim = (lim == 0) ? 0 : lim - 1;
    h.next_limit = (lim > DIST_NONE) ? DIST_NONE : lim[DW-1:0];
    return h;
  endfunction

  function automatic void add_row(logic [DW-1:0] d, logic [PW-1:0] p, logic l, logic typed,
                                  logic [DW-1:0] lim, shcc_pkg::verdict_t v,
                                  logic [PW-1:0] wpos, logic [DW-1:0] wdist);
    seed_row_t r;
    r.distance = d;
    r.position = p;
    r.last = l;
    r.typed = typed;
    r.want.next_limit = lim;
    r.want.verdict = v;
    r.want.position = wpos;
    r.want.distance = wdist;
    directed_rows.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (errors < MAX_PRINTS)
      $display("%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic send_seed(logic [DW-1:0] seed_dist, logic [PW-1:0] pos, logic last,
                           logic typed, hit_t want);
    hit_t pred;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    new_distance <= seed_dist;
    new_position <= pos;
    last_seed <= last;
    do @(posedge clk); while (!in_ready);
    pred = track_seed(seed_dist, pos, last);
    hits_due.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(logic [shcc_pkg::CFG_IDX_WIDTH-1:0] idx,
                           logic [shcc_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      shcc_pkg::CFG_ED_MAX: ed_max_reg = data;
      shcc_pkg::CFG_CONFIDENCE: conf_reg = data[shcc_pkg::CONF_WIDTH-1:0];
      shcc_pkg::CFG_SEED_TOTAL: seed_total_reg = data;
      default: ;
    endcase
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (hits_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // reads of a few seeds each, last seed flagged, with some noise items mixed in
  task automatic run_reads(int count);
    int left, len;
    logic [DW-1:0] d;
    hit_t none;
    none = '0;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_seed(DW'($urandom_range(0, 65535)), $urandom(), 1'($urandom_range(0, 1)),
                    1'b0, none);
        end else begin
          if ($urandom_range(0, 6) == 0) d = DIST_NONE;
          else d = DW'($urandom_range(0, ed_max_reg + conf_reg + 3));
          send_seed(d, $urandom(), (k == len - 1) || (left == 1), 1'b0, none);
        end
        left--;
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    hit_t due;
    if (!rst && out_valid && out_ready) begin
      if (hits_due.size() == 0) begin
        report_mismatch("unexpected result, verdict", verdict, 0);
      end else begin
        due = hits_due.pop_front();
        if (next_limit !== due.next_limit)
          report_mismatch("next_limit", next_limit, due.next_limit);
        if (verdict !== due.verdict)
          report_mismatch("verdict", verdict, due.verdict);
        if (best_position !== due.position)
          report_mismatch("best_position", best_position, due.position);
        if (best_distance !== due.distance)
          report_mismatch("best_distance", best_distance, due.distance);
      end
    end
  end

  initial begin
    int ed_sets[6];
    int conf_sets[6];
    int total_sets[6];
    int send_modes[4];
    int stall_modes[4];
    seed_row_t r;
    ed_sets = '{8, 1023, 0, 0, 20, 300};
    conf_sets = '{2, 1023, 1, 0, 3, 40};
    total_sets = '{4, 1023, 1, 0, 12, 60};
    send_modes = '{0, 71, 0, 33};
    stall_modes = '{0, 0, 71, 33};
    clear_read_state();

    // fresh read: none found, then a zero distance ends it as a single hit
    add_row(DIST_NONE, 32'h0, 1'b0, 1'b1, 16'd9, shcc_pkg::VERDICT_CONTINUE, 32'h0, DIST_NONE);
    add_row(16'd0, '1, 1'b0, 1'b1, 16'd9, shcc_pkg::VERDICT_SINGLE, '1, 16'd0);
    // early ambiguity
    add_row(16'd1, 32'hA5A5_5A5A, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd2, 32'h0000_1234, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    // all seeds without a match, position stays zero
    add_row(DIST_NONE, 32'h8000_0001, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(DIST_NONE, 32'h7FFF_FFFE, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(DIST_NONE, 32'h5A5A_A5A5, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(DIST_NONE, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'd9, shcc_pkg::VERDICT_NONE, 32'h0,
            DIST_NONE);
    // last seed endings: single, not found, multiple
    add_row(16'd5, 32'd7, 1'b1, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd9, 32'd3, 1'b1, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd7, 32'd10, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd8, 32'd11, 1'b1, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'h7FFF, 32'h0, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'hFFFE, 32'h1357_9BDF, 1'b1, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    // equal distance leaves state alone, in-between one becomes second
    add_row(16'd3, 32'h0000_0100, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd3, 32'h0000_0200, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd4, 32'h0000_0300, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(DIST_NONE, 32'h0000_0400, 1'b1, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd0, 32'd1, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);
    add_row(16'd1, 32'd2, 1'b0, 1'b0, '0, shcc_pkg::VERDICT_CONTINUE, '0, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_seed(r.distance, r.position, r.last, r.typed, r.want);
    end
    drain();

    for (int s = 0; s < 6; s++) begin
      write_reg(CFG_SPARE, shcc_pkg::CFG_DATA_WIDTH'($urandom_range(0, 1023)));
      write_reg(shcc_pkg::CFG_ED_MAX, shcc_pkg::CFG_DATA_WIDTH'(ed_sets[s]));
      write_reg(shcc_pkg::CFG_CONFIDENCE, shcc_pkg::CFG_DATA_WIDTH'(conf_sets[s]));
      write_reg(shcc_pkg::CFG_SEED_TOTAL, shcc_pkg::CFG_DATA_WIDTH'(total_sets[s]));
      cfg_valid <= 1'b0;
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = send_modes[m];
        stall_pct = stall_modes[m];
        run_reads(30);
        if (m == 1) drain();
      end
      if (s == 4) begin
        // long receiver hold-off while items keep coming
        send_idle_pct = 0;
        stall_pct = 0;
        holds_asked <= holds_asked + 1;
        run_reads(30);
      end
      drain();
    end

    @(negedge clk);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
